// ----- design/stw_pkg.sv -----
// Shared types and constants of the sliding time window traffic statistics block.
package stw_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TAIL_W   = CNT_W + 1;

	localparam int TIME_W   = 32;
	localparam int SIZE_W   = 16;
	localparam int PROTO_W  = 2;
	localparam int WIN_W    = 16;
	localparam int COUNT_W  = 11;
	localparam int BYTES_W  = 26;

	localparam logic [PROTO_W-1:0] CLASS_TCP = PROTO_W'(1);
	localparam logic [PROTO_W-1:0] CLASS_UDP = PROTO_W'(2);

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_AGE  = 1'b1;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);

	typedef struct packed {
		logic [TIME_W-1:0]  ts;
		logic [SIZE_W-1:0]  size;
		logic [PROTO_W-1:0] proto;
	} record_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVICT,
		ST_PUSH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic drop;
		logic push;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic expired;
		logic is_push;
	} ctrl_status_t;

endpackage

// ----- design/stw_ctrl.sv -----
// Controller state machine: sequences accept, eviction, push and result handoff.
module stw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  stw_pkg::ctrl_status_t status,
	output stw_pkg::ctrl_cmd_t    cmd
);

	stw_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stw_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			stw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = stw_pkg::ST_EVICT;
				end
			end
			stw_pkg::ST_EVICT: begin
				if (status.expired) begin
					cmd.drop = 1'b1;
				end else if (status.is_push) begin
					state_d = stw_pkg::ST_PUSH;
				end else begin
					state_d = stw_pkg::ST_DONE;
				end
			end
			stw_pkg::ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = stw_pkg::ST_DONE;
			end
			stw_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = stw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stw_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/stw_datapath.sv -----
// Datapath: record ring memory, head and count, running totals and result register.
module stw_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stw_pkg::ctrl_cmd_t            cmd,
	output stw_pkg::ctrl_status_t         status,
	input  logic                          cfg_we,
	input  logic [stw_pkg::WIN_W-1:0]     cfg_window,
	input  logic                          in_cmd,
	input  logic [stw_pkg::TIME_W-1:0]    in_now,
	input  logic [stw_pkg::SIZE_W-1:0]    in_size,
	input  logic [stw_pkg::PROTO_W-1:0]   in_proto,
	output logic [stw_pkg::COUNT_W-1:0]   record_count,
	output logic [stw_pkg::COUNT_W-1:0]   pkt_count,
	output logic [stw_pkg::COUNT_W-1:0]   tcp_pkt_count,
	output logic [stw_pkg::COUNT_W-1:0]   udp_pkt_count,
	output logic [stw_pkg::BYTES_W-1:0]   byte_count,
	output logic [stw_pkg::BYTES_W-1:0]   tcp_byte_count,
	output logic [stw_pkg::BYTES_W-1:0]   udp_byte_count,
	output logic                          dropped_oldest
);

	stw_pkg::record_t mem [stw_pkg::CAPACITY];
	stw_pkg::record_t rdata_q;

	logic [stw_pkg::WIN_W-1:0]   window_q;
	logic                        cmd_q;
	stw_pkg::record_t            rec_q;

	logic [stw_pkg::IDX_W-1:0]   head_q, head_d, tail;
	logic [stw_pkg::CNT_W-1:0]   count_q, count_d;
	logic [stw_pkg::CNT_W-1:0]   pk_q, tpk_q, upk_q, pk_d, tpk_d, upk_d;
	logic [stw_pkg::BYTES_W-1:0] by_q, tby_q, uby_q, by_d, tby_d, uby_d;
	logic                        dropped_q;

	logic [stw_pkg::TAIL_W-1:0]  tail_sum;
	logic [stw_pkg::TIME_W:0]    limit;
	logic                        full, drop, add_tcp, add_udp, sub_tcp, sub_udp;
	logic [stw_pkg::BYTES_W-1:0] add_sz, sub_sz;

	always_comb begin
		full     = (count_q == stw_pkg::CNT_W'(stw_pkg::CAPACITY));
		drop     = cmd.drop | (cmd.push & full);
		limit    = {1'b0, rdata_q.ts} + {{(stw_pkg::TIME_W + 1 - stw_pkg::WIN_W){1'b0}}, window_q};
		status.expired = (count_q != '0) && (limit < {1'b0, rec_q.ts});
		status.is_push = (cmd_q == stw_pkg::CMD_PUSH);

		tail_sum = stw_pkg::TAIL_W'(head_q) + stw_pkg::TAIL_W'(count_q);
		if (tail_sum >= stw_pkg::TAIL_W'(stw_pkg::CAPACITY)) begin
			tail_sum = tail_sum - stw_pkg::TAIL_W'(stw_pkg::CAPACITY);
		end
		tail = tail_sum[stw_pkg::IDX_W-1:0];

		head_d = head_q;
		if (drop) begin
			head_d = (head_q == stw_pkg::IDX_W'(stw_pkg::CAPACITY - 1)) ? '0 : head_q + 1'b1;
		end

		count_d = count_q;
		if (cmd.drop) begin
			count_d = count_q - 1'b1;
		end else if (cmd.push && !full) begin
			count_d = count_q + 1'b1;
		end

		sub_tcp = drop && (rdata_q.proto == stw_pkg::CLASS_TCP);
		sub_udp = drop && (rdata_q.proto == stw_pkg::CLASS_UDP);
		add_tcp = cmd.push && (rec_q.proto == stw_pkg::CLASS_TCP);
		add_udp = cmd.push && (rec_q.proto == stw_pkg::CLASS_UDP);
		sub_sz  = drop ? stw_pkg::BYTES_W'(rdata_q.size) : '0;
		add_sz  = cmd.push ? stw_pkg::BYTES_W'(rec_q.size) : '0;

		pk_d  = pk_q - stw_pkg::CNT_W'(drop) + stw_pkg::CNT_W'(cmd.push);
		tpk_d = tpk_q - stw_pkg::CNT_W'(sub_tcp) + stw_pkg::CNT_W'(add_tcp);
		upk_d = upk_q - stw_pkg::CNT_W'(sub_udp) + stw_pkg::CNT_W'(add_udp);
		by_d  = by_q - sub_sz + add_sz;
		tby_d = tby_q - (sub_tcp ? sub_sz : '0) + (add_tcp ? add_sz : '0);
		uby_d = uby_q - (sub_udp ? sub_sz : '0) + (add_udp ? add_sz : '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail] <= rec_q;
		end
		rdata_q <= mem[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= stw_pkg::WIN_RESET;
			head_q    <= '0;
			count_q   <= '0;
			pk_q      <= '0;
			tpk_q     <= '0;
			upk_q     <= '0;
			by_q      <= '0;
			tby_q     <= '0;
			uby_q     <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_window;
			end
			head_q  <= head_d;
			count_q <= count_d;
			pk_q    <= pk_d;
			tpk_q   <= tpk_d;
			upk_q   <= upk_d;
			by_q    <= by_d;
			tby_q   <= tby_d;
			uby_q   <= uby_d;
			if (cmd.load_in) begin
				dropped_q <= 1'b0;
			end else if (cmd.push && full) begin
				dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= in_cmd;
			rec_q <= '{ts: in_now, size: in_size, proto: in_proto};
		end
		if (cmd.load_out) begin
			record_count   <= stw_pkg::COUNT_W'(count_q);
			pkt_count      <= stw_pkg::COUNT_W'(pk_q);
			tcp_pkt_count  <= stw_pkg::COUNT_W'(tpk_q);
			udp_pkt_count  <= stw_pkg::COUNT_W'(upk_q);
			byte_count     <= by_q;
			tcp_byte_count <= tby_q;
			udp_byte_count <= uby_q;
			dropped_oldest <= dropped_q;
		end
	end

endmodule

// ----- design/sliding_time_window_traffic_stats.sv -----
// Sliding time window traffic statistics, top level.
// Each item (push or age) first evicts expired records from the head of a 1024-entry
// ring, one record per cycle, then appends on push, and yields one snapshot of the
// record count, the six packet and byte totals and the dropped-oldest flag. An item
// passes through the controller states idle (accept), evict, push (push items only)
// and done, and the next item is accepted only once the controller is back in idle.
// Its result is loaded into the output register in the done state, which waits while
// the previous result has not yet been taken. Eviction reads each head record through
// the single read port of the ring memory. A finished result sits in an output
// register, so the next item is accepted while it waits to be taken. Window writes
// are taken at any time on the configuration channel and must only be issued while
// the block is idle.
module sliding_time_window_traffic_stats (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [stw_pkg::WIN_W-1:0]      window_seconds,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [stw_pkg::TIME_W-1:0]     now,
	input  logic [stw_pkg::SIZE_W-1:0]     pkt_len,
	input  logic [stw_pkg::PROTO_W-1:0]    protocol,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [stw_pkg::COUNT_W-1:0]    record_count,
	output logic [stw_pkg::COUNT_W-1:0]    pkt_count,
	output logic [stw_pkg::COUNT_W-1:0]    tcp_pkt_count,
	output logic [stw_pkg::COUNT_W-1:0]    udp_pkt_count,
	output logic [stw_pkg::BYTES_W-1:0]    byte_count,
	output logic [stw_pkg::BYTES_W-1:0]    tcp_byte_count,
	output logic [stw_pkg::BYTES_W-1:0]    udp_byte_count,
	output logic                           dropped_oldest
);

	stw_pkg::ctrl_cmd_t    ctrl_cmd;
	stw_pkg::ctrl_status_t ctrl_status;

	assign cfg_ready = 1'b1;

	stw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (ctrl_status),
		.cmd       (ctrl_cmd)
	);

	stw_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctrl_cmd),
		.status         (ctrl_status),
		.cfg_we         (cfg_valid),
		.cfg_window     (window_seconds),
		.in_cmd         (cmd),
		.in_now         (now),
		.in_size        (pkt_len),
		.in_proto       (protocol),
		.record_count   (record_count),
		.pkt_count      (pkt_count),
		.tcp_pkt_count  (tcp_pkt_count),
		.udp_pkt_count  (udp_pkt_count),
		.byte_count     (byte_count),
		.tcp_byte_count (tcp_byte_count),
		.udp_byte_count (udp_byte_count),
		.dropped_oldest (dropped_oldest)
	);

`ifndef ASSERT_OFF
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in progress");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> record_count <= stw_pkg::COUNT_W'(stw_pkg::CAPACITY))
		else $error("record count exceeds capacity");

	a_drop_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_oldest |->
			record_count == stw_pkg::COUNT_W'(stw_pkg::CAPACITY))
		else $error("oldest record dropped without a full ring");

	a_class_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, tcp_pkt_count} + {1'b0, udp_pkt_count}) <= {1'b0, pkt_count}
			&& pkt_count == record_count)
		else $error("class packet totals inconsistent with overall total");
`endif

endmodule

// ----- test/testbench.sv -----
// Testbench for the sliding time window traffic statistics block: directed and random traffic.
`timescale 1ns / 100ps

module testbench;

	localparam logic [stw_pkg::PROTO_W-1:0] CLASS_OTHER = stw_pkg::PROTO_W'(0);
	localparam logic [stw_pkg::PROTO_W-1:0] CLASS_RSVD  = stw_pkg::PROTO_W'(3);

	typedef struct packed {
		logic                        cmd;
		logic [stw_pkg::TIME_W-1:0]  now;
		logic [stw_pkg::SIZE_W-1:0]  size;
		logic [stw_pkg::PROTO_W-1:0] proto;
	} packet_item_t;

	typedef struct packed {
		logic [stw_pkg::COUNT_W-1:0] record_count;
		logic [stw_pkg::COUNT_W-1:0] pkt_count;
		logic [stw_pkg::COUNT_W-1:0] tcp_pkt_count;
		logic [stw_pkg::COUNT_W-1:0] udp_pkt_count;
		logic [stw_pkg::BYTES_W-1:0] byte_count;
		logic [stw_pkg::BYTES_W-1:0] tcp_byte_count;
		logic [stw_pkg::BYTES_W-1:0] udp_byte_count;
		logic                        dropped_oldest;
	} snapshot_t;

	class window_stats_board;
		logic [stw_pkg::TIME_W-1:0]  ring_ts    [stw_pkg::CAPACITY];
		logic [stw_pkg::SIZE_W-1:0]  ring_size  [stw_pkg::CAPACITY];
		logic [stw_pkg::PROTO_W-1:0] ring_proto [stw_pkg::CAPACITY];
		logic [stw_pkg::WIN_W-1:0]   window;
		logic [stw_pkg::IDX_W-1:0]   head;
		logic [stw_pkg::CNT_W-1:0]   held;
		logic [stw_pkg::COUNT_W-1:0] pkts, tcp_pkts, udp_pkts;
		logic [stw_pkg::BYTES_W-1:0] bytes_all, bytes_tcp, bytes_udp;
		snapshot_t                   pending_snapshots[$];
		int                          errors;
		int                          results_seen;

		function new();
			window = stw_pkg::WIN_RESET;
			head = '0;
			held = '0;
			pkts = '0;
			tcp_pkts = '0;
			udp_pkts = '0;
			bytes_all = '0;
			bytes_tcp = '0;
			bytes_udp = '0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_window(logic [stw_pkg::WIN_W-1:0] w);
			window = w;
		endfunction

		function void account(logic [stw_pkg::IDX_W-1:0] slot, bit add);
			logic [stw_pkg::BYTES_W-1:0] sz;
			sz = stw_pkg::BYTES_W'(ring_size[slot]);
			if (add) begin
				pkts++;
				bytes_all += sz;
				if (ring_proto[slot] == stw_pkg::CLASS_TCP) begin
					tcp_pkts++;
					bytes_tcp += sz;
				end else if (ring_proto[slot] == stw_pkg::CLASS_UDP) begin
					udp_pkts++;
					bytes_udp += sz;
				end
			end else begin
				pkts--;
				bytes_all -= sz;
				if (ring_proto[slot] == stw_pkg::CLASS_TCP) begin
					tcp_pkts--;
					bytes_tcp -= sz;
				end else if (ring_proto[slot] == stw_pkg::CLASS_UDP) begin
					udp_pkts--;
					bytes_udp -= sz;
				end
			end
		endfunction

		function void drop_head();
			account(head, 1'b0);
			head++;
			held--;
		endfunction

		function bit head_expired(logic [stw_pkg::TIME_W-1:0] stamp);
			logic [stw_pkg::TIME_W:0] limit;
			limit = {1'b0, ring_ts[head]} +
				{{(stw_pkg::TIME_W + 1 - stw_pkg::WIN_W){1'b0}}, window};
			return limit < {1'b0, stamp};
		endfunction

		function void note_item(packet_item_t it);
			snapshot_t                 s;
			logic [stw_pkg::IDX_W-1:0] tail;
			s = '0;
			while (held != '0 && head_expired(it.now))
				drop_head();
			if (it.cmd == stw_pkg::CMD_PUSH) begin
				if (held == stw_pkg::CNT_W'(stw_pkg::CAPACITY)) begin
					drop_head();
					s.dropped_oldest = 1'b1;
				end
				tail = head + stw_pkg::IDX_W'(held);
				ring_ts[tail] = it.now;
				ring_size[tail] = it.size;
				ring_proto[tail] = it.proto;
				held++;
				account(tail, 1'b1);
			end
			s.record_count = held;
			s.pkt_count = pkts;
			s.tcp_pkt_count = tcp_pkts;
			s.udp_pkt_count = udp_pkts;
			s.byte_count = bytes_all;
			s.tcp_byte_count = bytes_tcp;
			s.udp_byte_count = bytes_udp;
			pending_snapshots.push_back(s);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("mismatch at %0t: %s", $time, msg);
		endtask

		task compare_field(string field, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0d want %0d",
					results_seen, field, got, want));
		endtask

		task check_snapshot(snapshot_t got);
			snapshot_t want;
			results_seen++;
			if (pending_snapshots.size() == 0) begin
				report($sformatf("result %0d arrived with no item pending", results_seen));
				return;
			end
			want = pending_snapshots.pop_front();
			compare_field("record_count", 64'(got.record_count), 64'(want.record_count));
			compare_field("pkt_count", 64'(got.pkt_count), 64'(want.pkt_count));
			compare_field("tcp_pkt_count", 64'(got.tcp_pkt_count), 64'(want.tcp_pkt_count));
			compare_field("udp_pkt_count", 64'(got.udp_pkt_count), 64'(want.udp_pkt_count));
			compare_field("byte_count", 64'(got.byte_count), 64'(want.byte_count));
			compare_field("tcp_byte_count", 64'(got.tcp_byte_count),
				64'(want.tcp_byte_count));
			compare_field("udp_byte_count", 64'(got.udp_byte_count),
				64'(want.udp_byte_count));
			compare_field("dropped_oldest", 64'(got.dropped_oldest),
				64'(want.dropped_oldest));
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [stw_pkg::WIN_W-1:0]   window_seconds;
	logic                        in_valid;
	logic                        in_ready;
	logic                        cmd;
	logic [stw_pkg::TIME_W-1:0]  now;
	logic [stw_pkg::SIZE_W-1:0]  pkt_len;
	logic [stw_pkg::PROTO_W-1:0] protocol;
	logic                        out_valid;
	logic                        out_ready;
	logic [stw_pkg::COUNT_W-1:0] record_count;
	logic [stw_pkg::COUNT_W-1:0] pkt_count;
	logic [stw_pkg::COUNT_W-1:0] tcp_pkt_count;
	logic [stw_pkg::COUNT_W-1:0] udp_pkt_count;
	logic [stw_pkg::BYTES_W-1:0] byte_count;
	logic [stw_pkg::BYTES_W-1:0] tcp_byte_count;
	logic [stw_pkg::BYTES_W-1:0] udp_byte_count;
	logic                        dropped_oldest;

	window_stats_board           board;
	int                          in_idle_pct = 0;
	int                          out_stall_pct = 0;
	int                          hold_left = 0;
	logic [stw_pkg::TIME_W-1:0]  traffic_now;

	sliding_time_window_traffic_stats u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.window_seconds (window_seconds),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.now            (now),
		.pkt_len        (pkt_len),
		.protocol       (protocol),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.record_count   (record_count),
		.pkt_count      (pkt_count),
		.tcp_pkt_count  (tcp_pkt_count),
		.udp_pkt_count  (udp_pkt_count),
		.byte_count     (byte_count),
		.tcp_byte_count (tcp_byte_count),
		.udp_byte_count (udp_byte_count),
		.dropped_oldest (dropped_oldest)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		snapshot_t seen;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				seen = {record_count, pkt_count, tcp_pkt_count, udp_pkt_count,
					byte_count, tcp_byte_count, udp_byte_count, dropped_oldest};
				board.check_snapshot(seen);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
			end
		end
	end

	task automatic send(logic op, logic [stw_pkg::TIME_W-1:0] stamp,
			logic [stw_pkg::SIZE_W-1:0] len, logic [stw_pkg::PROTO_W-1:0] proto);
		packet_item_t it;
		int           gap;
		it.cmd = op;
		it.now = stamp;
		it.size = len;
		it.proto = proto;
		gap = 0;
		while ($urandom_range(0, 99) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		now <= stamp;
		pkt_len <= len;
		protocol <= proto;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_item(it);
	endtask

	task quiesce();
		in_valid <= 1'b0;
		while (board.pending_snapshots.size() != 0) @(posedge clk);
	endtask

	task write_window(logic [stw_pkg::WIN_W-1:0] w);
		quiesce();
		cfg_valid <= 1'b1;
		window_seconds <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.set_window(w);
	endtask

	task automatic run_traffic(int count);
		int                         span;
		int                         r;
		logic [stw_pkg::SIZE_W-1:0] len;
		span = int'(board.window) + 1;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 1)
				traffic_now = $urandom;
			else if (r < 4)
				traffic_now = traffic_now - $urandom_range(0, span);
			else if (r < 14)
				traffic_now = traffic_now + $urandom_range(span / 2, span * 2);
			else if (r < 80)
				traffic_now = traffic_now + $urandom_range(0, span / 6 + 1);
			r = $urandom_range(0, 99);
			len = (r < 8) ? '0 : (r < 16) ? '1 : stw_pkg::SIZE_W'($urandom);
			send(($urandom_range(0, 99) < 22) ? stw_pkg::CMD_AGE : stw_pkg::CMD_PUSH,
				traffic_now, len, stw_pkg::PROTO_W'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		int idle_plan [4];
		int stall_plan [4];
		int win_plan [4];
		idle_plan = '{0, 74, 0, 37};
		stall_plan = '{0, 0, 74, 37};
		win_plan = '{12, 1, 65535, $urandom_range(2, 65534)};
		board = new();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		window_seconds <= '0;
		in_valid <= 1'b0;
		cmd <= stw_pkg::CMD_PUSH;
		now <= '0;
		pkt_len <= '0;
		protocol <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(stw_pkg::CMD_PUSH, 32'd0, '0, CLASS_OTHER);
		send(stw_pkg::CMD_PUSH, 32'd0, '1, stw_pkg::CLASS_TCP);
		send(stw_pkg::CMD_PUSH, 32'd5, 16'h1234, stw_pkg::CLASS_UDP);
		send(stw_pkg::CMD_PUSH, 32'd10, 16'hAAAA, CLASS_RSVD);
		send(stw_pkg::CMD_AGE, 32'd10, '1, CLASS_RSVD);
		send(stw_pkg::CMD_AGE, 32'd11, '0, CLASS_OTHER);
		send(stw_pkg::CMD_PUSH, 32'd3, 16'h5555, stw_pkg::CLASS_TCP);
		send(stw_pkg::CMD_AGE, 32'd15, '0, CLASS_OTHER);
		send(stw_pkg::CMD_AGE, 32'd16, '0, CLASS_OTHER);
		send(stw_pkg::CMD_AGE, 32'd100, '0, CLASS_OTHER);
		write_window('0);
		send(stw_pkg::CMD_PUSH, 32'd1000, 16'd7, stw_pkg::CLASS_TCP);
		send(stw_pkg::CMD_AGE, 32'd1000, '0, CLASS_OTHER);
		send(stw_pkg::CMD_AGE, 32'd1001, '0, CLASS_OTHER);
		write_window('1);
		send(stw_pkg::CMD_PUSH, 32'd2000, '1, stw_pkg::CLASS_UDP);
		send(stw_pkg::CMD_AGE, 32'd67535, '0, CLASS_OTHER);
		send(stw_pkg::CMD_AGE, 32'd67536, '0, CLASS_OTHER);
		send(stw_pkg::CMD_PUSH, 32'hFFFF_FFF0, '1, stw_pkg::CLASS_UDP);
		send(stw_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'd1, stw_pkg::CLASS_TCP);
		send(stw_pkg::CMD_AGE, 32'hFFFF_FFFF, '0, CLASS_OTHER);
		write_window(stw_pkg::WIN_RESET);
		send(stw_pkg::CMD_AGE, 32'hFFFF_FFFF, '0, CLASS_OTHER);

		for (int p = 0; p < 4; p++) begin
			write_window(stw_pkg::WIN_W'(win_plan[p]));
			in_idle_pct = idle_plan[p];
			out_stall_pct = stall_plan[p];
			traffic_now = $urandom_range(0, 32'h7FFF_FFFF);
			// hold the output long enough to back up the input
			if (p == 0)
				hold_left = 300;
			run_traffic(110);
		end

		quiesce();
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/stw_pkg.sv
design/stw_ctrl.sv
design/stw_datapath.sv
design/sliding_time_window_traffic_stats.sv
test/testbench.sv
